/* hdl/aacr_pkg.sv */
// ----------------------------------------------------------------------------
// aacr_pkg
// Shared types, widths and helpers of the collision resolver.
// ----------------------------------------------------------------------------
package aacr_pkg;

  localparam int unsigned COORD_W          = 16;
  localparam int unsigned SIZE_W           = 15;
  localparam int unsigned EDGE_W           = 17;
  localparam int unsigned WIDE_W           = 19;
  localparam int unsigned IDX_W            = 6;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned MAX_BOUNDS_DEF   = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_RESOLVE = 1'b1
  } req_e;

  typedef struct packed {
    logic                       req_type;
    logic [IDX_W-1:0]           entry_index;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic [SIZE_W-1:0]          rect_width;
    logic [SIZE_W-1:0]          rect_height;
    logic signed [COORD_W-1:0]  sprite_left;
    logic signed [COORD_W-1:0]  sprite_top;
    logic [SIZE_W-1:0]          sprite_width;
    logic [SIZE_W-1:0]          sprite_height;
    logic signed [COORD_W-1:0]  offset_x;
    logic signed [COORD_W-1:0]  offset_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  hitbox_left_out;
    logic signed [COORD_W-1:0]  hitbox_top_out;
    logic signed [COORD_W-1:0]  sprite_left_out;
    logic signed [COORD_W-1:0]  sprite_top_out;
    logic                       clear_vel_x;
    logic                       clear_vel_y;
    logic                       ground_contact;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    req_e                       kind;
    logic                       wr_ok;
    logic [IDX_W-1:0]           idx;
    logic signed [COORD_W-1:0]  left;
    logic signed [COORD_W-1:0]  top;
    logic [SIZE_W-1:0]          width;
    logic [SIZE_W-1:0]          height;
    logic signed [EDGE_W-1:0]   right;
    logic signed [EDGE_W-1:0]   bottom;
    logic signed [COORD_W-1:0]  spr_left;
    logic signed [COORD_W-1:0]  spr_top;
    logic [SIZE_W-1:0]          spr_width;
    logic [SIZE_W-1:0]          spr_height;
    logic signed [COORD_W-1:0]  ofs_x;
    logic signed [COORD_W-1:0]  ofs_y;
  } cmd_t;

  function automatic logic signed [WIDE_W-1:0] sz_wide(input logic [SIZE_W-1:0] v);
    return $signed({{(WIDE_W-SIZE_W){1'b0}}, v});
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32767);
    lo = -WIDE_W'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

/* hdl/aacr_if.sv */
// ----------------------------------------------------------------------------
// aacr_in_if / aacr_out_if
// Valid-ready channels of the collision resolver.
// ----------------------------------------------------------------------------
interface aacr_in_if;
  import aacr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface aacr_out_if;
  import aacr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* hdl/aacr_front.sv */
// ----------------------------------------------------------------------------
// aacr_front
// Accepts items, classifies them and precomputes rectangle edges.
// ----------------------------------------------------------------------------
module aacr_front #(
  parameter int unsigned MaxBoundaries = aacr_pkg::MAX_BOUNDS_DEF
) (
  aacr_in_if.sink         in_i,
  output aacr_pkg::cmd_t  cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i
);
  import aacr_pkg::*;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    cmd_o.kind       = req_e'(in_i.item.req_type);
    cmd_o.wr_ok      = int'(in_i.item.entry_index) < int'(MaxBoundaries);
    cmd_o.idx        = in_i.item.entry_index;
    cmd_o.left       = in_i.item.rect_left;
    cmd_o.top        = in_i.item.rect_top;
    cmd_o.width      = in_i.item.rect_width;
    cmd_o.height     = in_i.item.rect_height;
    // right and bottom edges, exact
    cmd_o.right      = EDGE_W'(in_i.item.rect_left)
                       + $signed({2'b00, in_i.item.rect_width});
    cmd_o.bottom     = EDGE_W'(in_i.item.rect_top)
                       + $signed({2'b00, in_i.item.rect_height});
    cmd_o.spr_left   = in_i.item.sprite_left;
    cmd_o.spr_top    = in_i.item.sprite_top;
    cmd_o.spr_width  = in_i.item.sprite_width;
    cmd_o.spr_height = in_i.item.sprite_height;
    cmd_o.ofs_x      = in_i.item.offset_x;
    cmd_o.ofs_y      = in_i.item.offset_y;
  end

endmodule

/* hdl/aacr_queue.sv */
// ----------------------------------------------------------------------------
// aacr_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module aacr_queue #(
  parameter int unsigned Depth = aacr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  aacr_pkg::cmd_t  wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output aacr_pkg::cmd_t  rd_data_o
);
  import aacr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign wr_ready_o = count_q != CntW'(Depth);
  assign rd_valid_o = count_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/aacr_back.sv */
// ----------------------------------------------------------------------------
// aacr_back
// Boundary table, entry walk with push-out and the result register.
// ----------------------------------------------------------------------------
module aacr_back #(
  parameter int unsigned MaxBoundaries = aacr_pkg::MAX_BOUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aacr_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  aacr_pkg::cmd_t                cmd_i,
  aacr_out_if.source                    out_o
);
  import aacr_pkg::*;

  localparam int unsigned AddrW = (MaxBoundaries > 1) ? $clog2(MaxBoundaries) : 1;
  localparam int unsigned CntW  = $clog2(MaxBoundaries + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
  } entry_t;

  entry_t                    mem [MaxBoundaries];
  entry_t                    rdata_q;
  state_e                    state_q;
  logic [COUNT_W-1:0]        count_q;
  logic [CntW-1:0]           issue_q;
  logic [CntW-1:0]           limit_q;
  logic                      rv_q;
  logic signed [COORD_W-1:0] hl_q, ht_q, sl_q, st_q, ox_q, oy_q;
  logic signed [EDGE_W-1:0]  hr_q, hb_q;
  logic [SIZE_W-1:0]         hw_q, hh_q, sw_q, sh_q;
  logic                      cvx_q, cvy_q, gnd_q;
  logic                      out_valid_q;
  out_item_t                 out_item_q;

  logic                      pop;
  logic                      issue_go;
  logic [CntW-1:0]           limit;
  logic                      hit;
  logic signed [WIDE_W-1:0]  fl, fr, ft, fb, mx, my;
  logic                      left_side, top_side, horiz;
  logic signed [COORD_W-1:0] hl_push, sl_push, ht_push, st_push;

  assign cmd_ready_o = state_q == ST_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign issue_go    = (state_q == ST_WALK) && (issue_q != limit_q);
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  always_comb begin
    if (int'(count_q) > int'(MaxBoundaries)) begin
      limit = CntW'(MaxBoundaries);
    end else begin
      limit = CntW'(count_q);
    end
  end

  // one entry check against the current hitbox
  always_comb begin
    hit = (rdata_q.width != '0) && (rdata_q.height != '0) &&
          (hw_q != '0) && (hh_q != '0) &&
          (hl_q < rdata_q.right) && (rdata_q.left < hr_q) &&
          (ht_q < rdata_q.bottom) && (rdata_q.top < hb_q);
    fr = WIDE_W'(rdata_q.right) - WIDE_W'(hl_q);
    fl = WIDE_W'(hr_q) - WIDE_W'(rdata_q.left);
    fb = WIDE_W'(rdata_q.bottom) - WIDE_W'(ht_q);
    ft = WIDE_W'(hb_q) - WIDE_W'(rdata_q.top);
    left_side = fl < fr;
    top_side  = ft < fb;
    mx        = left_side ? fl : fr;
    my        = top_side ? ft : fb;
    horiz     = mx < my;
    if (left_side) begin
      hl_push = sat16(WIDE_W'(rdata_q.left) - sz_wide(hw_q));
      sl_push = sat16(WIDE_W'(rdata_q.left) - sz_wide(sw_q) + WIDE_W'(ox_q));
    end else begin
      hl_push = sat16(WIDE_W'(rdata_q.right));
      sl_push = sat16(WIDE_W'(rdata_q.right) - WIDE_W'(ox_q));
    end
    if (top_side) begin
      ht_push = sat16(WIDE_W'(rdata_q.top) - sz_wide(hh_q));
      st_push = sat16(WIDE_W'(rdata_q.top) - sz_wide(sh_q) + WIDE_W'(oy_q));
    end else begin
      ht_push = sat16(WIDE_W'(rdata_q.bottom));
      st_push = sat16(WIDE_W'(rdata_q.bottom) - WIDE_W'(oy_q));
    end
  end

  // boundary table
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.kind == REQ_LOAD) && cmd_i.wr_ok) begin
      mem[AddrW'(cmd_i.idx)] <= '{left: cmd_i.left, top: cmd_i.top,
                                  width: cmd_i.width, height: cmd_i.height,
                                  right: cmd_i.right, bottom: cmd_i.bottom};
    end
    if (issue_go) begin
      rdata_q <= mem[issue_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      limit_q     <= '0;
      rv_q        <= 1'b0;
      hl_q        <= '0;
      ht_q        <= '0;
      hr_q        <= '0;
      hb_q        <= '0;
      hw_q        <= '0;
      hh_q        <= '0;
      sl_q        <= '0;
      st_q        <= '0;
      sw_q        <= '0;
      sh_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      cvx_q       <= 1'b0;
      cvy_q       <= 1'b0;
      gnd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop && (cmd_i.kind == REQ_RESOLVE)) begin
            hl_q    <= cmd_i.left;
            ht_q    <= cmd_i.top;
            hr_q    <= cmd_i.right;
            hb_q    <= cmd_i.bottom;
            hw_q    <= cmd_i.width;
            hh_q    <= cmd_i.height;
            sl_q    <= cmd_i.spr_left;
            st_q    <= cmd_i.spr_top;
            sw_q    <= cmd_i.spr_width;
            sh_q    <= cmd_i.spr_height;
            ox_q    <= cmd_i.ofs_x;
            oy_q    <= cmd_i.ofs_y;
            cvx_q   <= 1'b0;
            cvy_q   <= 1'b0;
            gnd_q   <= 1'b0;
            issue_q <= '0;
            limit_q <= limit;
            rv_q    <= 1'b0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          rv_q <= issue_go;
          if (issue_go) begin
            issue_q <= issue_q + 1'b1;
          end
          if (rv_q && hit) begin
            if (horiz) begin
              hl_q  <= hl_push;
              hr_q  <= EDGE_W'(hl_push) + $signed({2'b00, hw_q});
              sl_q  <= sl_push;
              cvx_q <= 1'b1;
            end else begin
              ht_q  <= ht_push;
              hb_q  <= EDGE_W'(ht_push) + $signed({2'b00, hh_q});
              st_q  <= st_push;
              cvy_q <= 1'b1;
              if (top_side) begin
                gnd_q <= 1'b1;
              end
            end
          end
          if (!issue_go && !rv_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{hitbox_left_out: hl_q, hitbox_top_out: ht_q,
                             sprite_left_out: sl_q, sprite_top_out: st_q,
                             clear_vel_x: cvx_q, clear_vel_y: cvy_q,
                             ground_contact: gnd_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/aabb_collision_resolver.sv */
// ----------------------------------------------------------------------------
// aabb_collision_resolver
// Pushes a unit hitbox out of a table of solid rectangles.
//
//   channel  dir  handshake            payload
//   in_i     in   valid / ready        load or resolve item
//   out_o    out  valid / ready        resolved positions and flags
//   cfg      in   cfg_we_i             boundary_count
//
// a load item writes its table entry as the back end takes it; the back end stays idle
// with n = min(boundary_count, MaxBoundaries), a resolve item holds the back end
// while the walk reads and checks one table entry per cycle, entries 0 to n-1;
// the result is then registered in ST_DONE and the back end returns to idle
// the two-entry queue takes items while the back end walks; the input stalls when
// it is full, and the back end stalls while an earlier result waits
// reset clears control, working and result registers; table entries are undefined until loaded
// ----------------------------------------------------------------------------
module aabb_collision_resolver #(
  parameter int unsigned MaxBoundaries = aacr_pkg::MAX_BOUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aacr_pkg::COUNT_W-1:0]  cfg_wdata_i,
  aacr_in_if.sink                       in_i,
  aacr_out_if.source                    out_o
);
  import aacr_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  aacr_front #(
    .MaxBoundaries(MaxBoundaries)
  ) u_front (
    .in_i       (in_i),
    .cmd_o      (front_cmd),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready)
  );

  aacr_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .wr_data_i (front_cmd),
    .rd_valid_o(back_valid),
    .rd_ready_i(back_ready),
    .rd_data_o (back_cmd)
  );

  aacr_back #(
    .MaxBoundaries(MaxBoundaries)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(back_valid),
    .cmd_ready_o(back_ready),
    .cmd_i      (back_cmd),
    .out_o      (out_o)
  );

endmodule

/* hdl/aacr_checker.sv */
// ----------------------------------------------------------------------------
// aacr_checker
// Port-level checks of the collision resolver, bound to the top level.
// ----------------------------------------------------------------------------
module aacr_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 in_req_type_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input aacr_pkg::out_item_t  out_item_i
);
  import aacr_pkg::*;

  localparam int unsigned PendMax = QUEUE_DEPTH + 2;

  logic [3:0] pend_q;
  logic       res_acc;
  logic       out_acc;

  assign res_acc = in_valid_i && in_ready_i && (in_req_type_i == REQ_RESOLVE);
  assign out_acc = out_valid_i && out_ready_i;

  // resolve items in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (res_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !res_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  a_ground_vertical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.ground_contact |-> out_item_i.clear_vel_y)
    else $error("ground contact without vertical push");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result without a pending resolve item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(PendMax))
    else $error("too many resolve items in flight");

endmodule

bind aabb_collision_resolver aacr_checker u_aacr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_req_type_i(in_i.item.req_type),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_item_i   (out_o.item)
);
